### src/tdte_pkg.sv
// Package with the shared types, constants and character functions of the date/time extractor.
package tdte_pkg;

    localparam logic [7:0] YEAR_CENTURY = 8'h20;
    localparam logic [2:0] TIME_DIGITS = 3'd6;
    localparam logic [2:0] RUN_SATURATE = 3'd7;
    localparam logic [2:0] YEAR_DIGITS = 3'd4;
    localparam logic [2:0] DAY_DIGITS = 3'd2;
    localparam logic [1:0] MONTH_LETTERS_HELD = 2'd2;

    typedef enum logic [1:0] {
        DATE_SEARCH  = 2'd0,
        DATE_LETTERS = 2'd1,
        DATE_FOUND   = 2'd2,
        DATE_FAILED  = 2'd3
    } tdte_date_stage_t;

    typedef struct packed {
        logic [2:0]       run_length;
        logic [23:0]      run_digits;
        logic             time_found;
        logic [23:0]      time_value;
        logic             year_found;
        logic [7:0]       year_value;
        tdte_date_stage_t date_stage;
        logic [15:0]      letters_held;
        logic [1:0]       letter_count;
        logic [12:0]      date_value;
    } tdte_state_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] hours;
        logic [7:0] minutes;
        logic [7:0] seconds;
        logic [7:0] day;
        logic [4:0] month;
        logic [7:0] year_low;
    } tdte_result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    // Returns the BCD month for an upper-case abbreviation, or zero when none matches.
    function automatic logic [4:0] month_bcd(input logic [23:0] name);
        logic [4:0] m;
        case (name)
            "JAN":   m = 5'h01;
            "FEB":   m = 5'h02;
            "MAR":   m = 5'h03;
            "APR":   m = 5'h04;
            "MAY":   m = 5'h05;
            "JUN":   m = 5'h06;
            "JUL":   m = 5'h07;
            "AUG":   m = 5'h08;
            "SEP":   m = 5'h09;
            "OCT":   m = 5'h10;
            "NOV":   m = 5'h11;
            "DEC":   m = 5'h12;
            default: m = 5'h00;
        endcase
        return m;
    endfunction

endpackage

### src/tdte_in_if.sv
// Channel interface that carries one character item of a text line.
interface tdte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

### src/tdte_out_if.sv
// Channel interface that carries one extracted date/time result item.
interface tdte_out_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
    logic [7:0] day;
    logic [4:0] month;
    logic [7:0] year_low;

    modport source (output valid, output ok, output hours, output minutes, output seconds,
                    output day, output month, output year_low, input ready);
    modport sink (input valid, input ok, input hours, input minutes, input seconds,
                  input day, input month, input year_low, output ready);
endinterface

### src/tdte_next.sv
// Next-state and result logic of the extractor for one accepted character.
module tdte_next (
    input  tdte_pkg::tdte_state_t  cur,
    input  logic [7:0]             ch,
    input  logic                   last,
    output tdte_pkg::tdte_state_t  nxt,
    output tdte_pkg::tdte_result_t result
);
    import tdte_pkg::*;

    tdte_state_t upd;
    logic        dig;
    logic        let_c;
    logic [4:0]  month_code;
    logic [2:0]  new_length;
    logic [23:0] new_digits;
    logic [2:0]  chk_length;
    logic [23:0] chk_digits;
    logic        chk_en;

    assign dig = is_digit(ch);
    assign let_c = is_letter(ch);
    assign month_code = month_bcd({cur.letters_held, ch});

    always_comb
    begin
        new_digits = (cur.run_length < TIME_DIGITS) ? {cur.run_digits[19:0], ch[3:0]}
                                                    : cur.run_digits;
        new_length = (cur.run_length < RUN_SATURATE) ? cur.run_length + 3'd1 : cur.run_length;
        chk_length = dig ? new_length : cur.run_length;
        chk_digits = dig ? new_digits : cur.run_digits;
        chk_en = !dig || last;

        upd = cur;

        // The date search runs on the run length that was in place before this character.
        case (cur.date_stage)
            DATE_LETTERS:
            begin
                if (let_c) begin
                    if (cur.letter_count >= MONTH_LETTERS_HELD) begin
                        if (month_code != 5'h00) begin
                            upd.date_value = {cur.date_value[12:5], month_code};
                            upd.date_stage = DATE_FOUND;
                        end else begin
                            upd.date_stage = DATE_FAILED;
                        end
                    end else begin
                        upd.letters_held = {cur.letters_held[7:0], ch};
                        upd.letter_count = cur.letter_count + 2'd1;
                    end
                end else begin
                    upd.date_stage = DATE_SEARCH;
                    upd.letter_count = 2'd0;
                    upd.letters_held = 16'h0000;
                end
            end
            DATE_SEARCH:
            begin
                if (let_c && (cur.run_length == DAY_DIGITS)) begin
                    upd.date_stage = DATE_LETTERS;
                    upd.letters_held = {8'h00, ch};
                    upd.letter_count = 2'd1;
                    upd.date_value = {cur.run_digits[7:0], 5'h00};
                end
            end
            default:
            begin
                upd.date_stage = cur.date_stage;
            end
        endcase

        if (dig) begin
            upd.run_digits = new_digits;
            upd.run_length = new_length;
            if (!cur.time_found && (new_length == TIME_DIGITS)) begin
                upd.time_found = 1'b1;
                upd.time_value = new_digits;
            end
        end else begin
            upd.run_length = 3'd0;
            upd.run_digits = 24'h000000;
        end

        // A closed run of exactly four digits starting with the century is the year.
        if (chk_en && !cur.year_found && (chk_length == YEAR_DIGITS)
            && (chk_digits[15:8] == YEAR_CENTURY)) begin
            upd.year_found = 1'b1;
            upd.year_value = chk_digits[7:0];
        end

        result.ok = upd.time_found && upd.year_found && (upd.date_stage == DATE_FOUND);
        result.hours = result.ok ? upd.time_value[23:16] : 8'h00;
        result.minutes = result.ok ? upd.time_value[15:8] : 8'h00;
        result.seconds = result.ok ? upd.time_value[7:0] : 8'h00;
        result.day = result.ok ? upd.date_value[12:5] : 8'h00;
        result.month = result.ok ? upd.date_value[4:0] : 5'h00;
        result.year_low = result.ok ? upd.year_value : 8'h00;

        nxt = last ? tdte_state_t'('0) : upd;
    end

endmodule

### src/text_date_time_extractor.sv
// Top level of the text line date/time extractor: scan state, result register and handshakes.
//
// The block takes one character item per clock cycle and answers once per line: the result
// item for a line appears in the cycle after the character marked last is accepted, carrying
// BCD time, day, month and year digits and an ok flag (all fields zero when ok is low). The
// per-character scan, including the twelve month-name compares, is a single combinational
// step in front of the state registers, so the sustained rate is one character per cycle.
// A single output register holds the result. While a result waits there, the input is held
// off; in the cycle the result is taken a new character is accepted as well, so characters
// keep flowing at full rate whenever the receiver is ready.
module text_date_time_extractor (
    input logic        clk,
    input logic        rst_n,
    tdte_in_if.sink    char_chan,
    tdte_out_if.source result_chan
);
    import tdte_pkg::*;

    tdte_state_t  state_reg;
    tdte_state_t  state_next;
    tdte_result_t result_reg;
    tdte_result_t result_next;
    logic         out_valid_reg;
    logic         accept;

    assign char_chan.ready = !out_valid_reg || result_chan.ready;
    assign accept = char_chan.valid && char_chan.ready;

    tdte_next u_next (
        .cur    (state_reg),
        .ch     (char_chan.ch),
        .last   (char_chan.last),
        .nxt    (state_next),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            if (accept && char_chan.last) begin
                out_valid_reg <= 1'b1;
            end else if (result_chan.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && char_chan.last) begin
            result_reg <= result_next;
        end
    end

    assign result_chan.valid = out_valid_reg;
    assign result_chan.ok = result_reg.ok;
    assign result_chan.hours = result_reg.hours;
    assign result_chan.minutes = result_reg.minutes;
    assign result_chan.seconds = result_reg.seconds;
    assign result_chan.day = result_reg.day;
    assign result_chan.month = result_reg.month;
    assign result_chan.year_low = result_reg.year_low;

`ifndef NO_ASSERTIONS
    a_line_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && char_chan.last) |=> result_chan.valid)
        else $error("No result after the last character of a line.");

    a_line_end_clears_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && char_chan.last) |=>
            (state_reg.run_length == 3'd0 && state_reg.date_stage == DATE_SEARCH
             && !state_reg.time_found && !state_reg.year_found))
        else $error("Scan state not cleared after a line.");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !char_chan.last && !result_chan.valid) |=> !result_chan.valid)
        else $error("Result raised without a line end.");

    a_ok_has_month: assert property (@(posedge clk) disable iff (!rst_n)
        (result_chan.valid && result_chan.ok) |-> (result_chan.month != 5'h00))
        else $error("Successful result without a month.");

    a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_chan.valid && !result_chan.ok) |->
            (result_chan.hours == 8'h00 && result_chan.day == 8'h00
             && result_chan.month == 5'h00 && result_chan.year_low == 8'h00))
        else $error("Failed result carries nonzero fields.");
`endif

endmodule
